[hdl/watchdog_supervision_manager_defines.svh]
// ----------------------------------------------------------------------------
// Watchdog supervision manager assertion macros
// Shared concurrent assertion wrappers for the supervision manager RTL.
// ----------------------------------------------------------------------------
`ifndef WATCHDOG_SUPERVISION_MANAGER_DEFINES_SVH
`define WATCHDOG_SUPERVISION_MANAGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define WSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define WSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/wsm_pkg.sv]
// ----------------------------------------------------------------------------
// Watchdog supervision manager package
// Types, codes and helper functions shared by the supervision manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsm_pkg;

	localparam int NUM_ENTITIES_DEF = 16;
	localparam int MAX_SEQ_DEF      = 8;

	// Sequence counters hold up to MAX_SEQ + 1 for any supported MAX_SEQ.
	localparam int CNT_W = 7;

	localparam logic [3:0] REQ_REG_ALIVE    = 4'd0;
	localparam logic [3:0] REQ_REG_DEADLINE = 4'd1;
	localparam logic [3:0] REQ_SEQ_ELEM     = 4'd2;
	localparam logic [3:0] REQ_HEARTBEAT    = 4'd3;
	localparam logic [3:0] REQ_DL_START     = 4'd4;
	localparam logic [3:0] REQ_DL_END       = 4'd5;
	localparam logic [3:0] REQ_CHECKPOINT   = 4'd6;
	localparam logic [3:0] REQ_VERIFY       = 4'd7;
	localparam logic [3:0] REQ_CHECK_ALL    = 4'd8;
	localparam logic [3:0] REQ_QUERY        = 4'd9;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EXPIRED = 2'd1;
	localparam logic [1:0] ST_WRONG   = 2'd2;
	localparam logic [1:0] ST_DEACT   = 2'd3;

	localparam logic [1:0] ACT_NONE      = 2'd0;
	localparam logic [1:0] ACT_RESTART   = 2'd1;
	localparam logic [1:0] ACT_PARTITION = 2'd2;
	localparam logic [1:0] ACT_SAFE      = 2'd3;

	localparam logic [1:0] CFG_RESTART   = 2'd0;
	localparam logic [1:0] CFG_PARTITION = 2'd1;
	localparam logic [1:0] CFG_SAFE      = 2'd2;

	localparam logic [15:0] RESTART_RST   = 16'd1;
	localparam logic [15:0] PARTITION_RST = 16'd3;
	localparam logic [15:0] SAFE_RST      = 16'd5;

	typedef struct packed {
		logic [15:0] budget;
		logic [15:0] tolerance;
		logic [15:0] period;
		logic [3:0]  seq_length;
		logic [2:0]  seq_index;
		logic [7:0]  checkpoint_value;
		logic [31:0] now_time;
		logic [3:0]  entity;
		logic [3:0]  req_type;
	} req_t;

	typedef struct packed {
		logic        last;
		logic        pass;
		logic [1:0]  action;
		logic        fault;
		logic [15:0] failures;
		logic [1:0]  status;
		logic        known;
		logic [3:0]  entity_out;
	} res_t;

	typedef struct packed {
		logic [15:0] restart;
		logic [15:0] partition;
		logic [15:0] safe;
	} thr_t;

	// One entity record as held in the entity table.
	typedef struct packed {
		logic             present;
		logic             alive_on;
		logic             deadline_on;
		logic             logical_on;
		logic             running;
		logic [CNT_W-1:0] exp_cnt;
		logic [CNT_W-1:0] seen_cnt;
		logic [1:0]       status;
		logic [15:0]      fails;
		logic [15:0]      period;
		logic [15:0]      margin;
		logic [31:0]      last_hb;
		logic [15:0]      budget;
		logic [31:0]      dl_begin;
	} rec_t;

	// One checkpoint slot: expected element and observed element.
	typedef struct packed {
		logic [7:0] exp_val;
		logic [7:0] seen_val;
	} seq_t;

	localparam int REC_W = $bits(rec_t);
	localparam int SEQ_W = $bits(seq_t);

	function automatic logic [1:0] pick_action(input logic [15:0] cnt, input thr_t thr);
		logic [1:0] act;
		if (cnt >= thr.safe) act = ACT_SAFE;
		else if (cnt >= thr.partition) act = ACT_PARTITION;
		else if (cnt >= thr.restart) act = ACT_RESTART;
		else act = ACT_NONE;
		return act;
	endfunction

endpackage

[hdl/wsm_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/wsm_core.sv]
// ----------------------------------------------------------------------------
// Watchdog supervision engine
// Sequencer that reads, updates and writes back the entity and checkpoint
// tables, and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "watchdog_supervision_manager_defines.svh"

module wsm_core import wsm_pkg::*; #(
	parameter int NUM_ENTITIES = NUM_ENTITIES_DEF,
	parameter int MAX_SEQ      = MAX_SEQ_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	input  thr_t thr,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int EAW   = (NUM_ENTITIES > 1) ? $clog2(NUM_ENTITIES) : 1;
	localparam int SAW   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
	localparam int EDEPTH = 2 ** EAW;
	localparam int SDEPTH = 2 ** (EAW + SAW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_REC  = 3'd1;
	localparam logic [2:0] S_SEQ  = 3'd2;
	localparam logic [2:0] S_VER  = 3'd3;
	localparam logic [2:0] S_CA   = 3'd4;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEQ);

	logic [2:0]          state_q, nxt;
	req_t                req_q;
	logic                ent_ok_q;
	logic [EAW-1:0]      ent_addr;
	logic [EAW-1:0]      ca_idx_q;
	logic [SAW-1:0]      vidx_q;
	logic [EDEPTH-1:0]   valid_q;
	logic                vld_s1;
	logic                out_vld_q;
	res_t                out_q;

	logic                rec_re, rec_we;
	logic [EAW-1:0]      rec_ra, rec_wa;
	logic [REC_W-1:0]    rec_raw;
	rec_t                rec_rd, rec_cur, rec_wd, su_rec, ca_rec;
	logic                seq_re, seq_we;
	logic [EAW+SAW-1:0]  seq_ra, seq_ra_q;
	logic [SEQ_W-1:0]    seq_raw;
	seq_t                seq_rd, seq_wd;

	logic                can_emit, emit, ca_inc, vidx_inc, ca_last;
	logic [15:0]         fails_inc;
	logic [1:0]          fail_act;
	logic                dl_over, alive_over, cp_mism, ver_bad, verify_ok;
	logic                su_fault, su_pass, do_fail, known_s, ca_fail;
	logic [1:0]          fail_why;
	logic                need_seq, need_ver, rec_write_ok;
	logic [SAW-1:0]      seq_idx_sel;
	logic [CNT_W-1:0]    slen_sat;
	res_t                res_s, res_ca, res;

	wsm_ram #(.WIDTH(REC_W), .DEPTH(EDEPTH)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_wa),
		.wdata (rec_wd),
		.re    (rec_re),
		.raddr (rec_ra),
		.rdata (rec_raw)
	);

	wsm_ram #(.WIDTH(SEQ_W), .DEPTH(SDEPTH)) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (seq_ra_q),
		.wdata (seq_wd),
		.re    (seq_re),
		.raddr (seq_ra),
		.rdata (seq_raw)
	);

	assign rec_rd  = rec_t'(rec_raw);
	assign seq_rd  = seq_t'(seq_raw);
	// An entity never written reads as its cleared reset record.
	assign rec_cur = vld_s1 ? rec_rd : '0;

	assign ent_addr  = EAW'(req_q.entity);
	assign can_emit  = !out_vld_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign out_res   = out_q;
	assign ca_last   = (ca_idx_q == EAW'(NUM_ENTITIES - 1));

	assign fails_inc = (rec_cur.fails == 16'hFFFF) ? rec_cur.fails : rec_cur.fails + 16'd1;
	assign fail_act  = pick_action(fails_inc, thr);

	assign dl_over    = (req_q.now_time - rec_cur.dl_begin) > {16'd0, rec_cur.budget};
	assign alive_over = (req_q.now_time - rec_cur.last_hb) >
		(32'(rec_cur.period) + 32'(rec_cur.margin));
	assign cp_mism    = (state_q == S_SEQ) && (rec_cur.seen_cnt < rec_cur.exp_cnt) &&
		(seq_rd.exp_val != req_q.checkpoint_value);
	assign ver_bad    = (state_q == S_VER) && (seq_rd.exp_val != seq_rd.seen_val);
	assign verify_ok  = (rec_cur.seen_cnt == rec_cur.exp_cnt) &&
		(rec_cur.seen_cnt <= MAX_CNT) && !ver_bad;
	assign slen_sat   = (CNT_W'(req_q.seq_length) > MAX_CNT) ? MAX_CNT :
		CNT_W'(req_q.seq_length);

	assign need_seq = ent_ok_q && (
		((req_q.req_type == REQ_SEQ_ELEM) && (CNT_W'(req_q.seq_index) < MAX_CNT)) ||
		((req_q.req_type == REQ_CHECKPOINT) && rec_cur.present &&
			(rec_cur.seen_cnt < MAX_CNT)));
	assign need_ver = ent_ok_q && rec_cur.present && (req_q.req_type == REQ_VERIFY) &&
		(rec_cur.seen_cnt == rec_cur.exp_cnt) && (rec_cur.seen_cnt != '0) &&
		(rec_cur.seen_cnt <= MAX_CNT);
	assign seq_idx_sel = (req_q.req_type == REQ_SEQ_ELEM) ? SAW'(req_q.seq_index) :
		SAW'(rec_cur.seen_cnt);
	assign rec_write_ok = ent_ok_q && ((req_q.req_type <= REQ_SEQ_ELEM) || rec_cur.present);

	// Record update for a single-entity request.
	always_comb begin
		su_rec   = rec_cur;
		su_pass  = 1'b0;
		do_fail  = 1'b0;
		fail_why = ST_EXPIRED;
		if (ent_ok_q && (req_q.req_type <= REQ_SEQ_ELEM)) begin
			su_rec.present = 1'b1;
			su_rec.status  = ST_OK;
			case (req_q.req_type)
				REQ_REG_ALIVE: begin
					su_rec.period   = req_q.period;
					su_rec.margin   = req_q.tolerance;
					su_rec.last_hb  = req_q.now_time;
					su_rec.alive_on = 1'b1;
				end
				REQ_REG_DEADLINE: begin
					su_rec.budget      = req_q.budget;
					su_rec.deadline_on = 1'b1;
				end
				default: begin
					su_rec.exp_cnt    = slen_sat;
					su_rec.logical_on = 1'b1;
				end
			endcase
		end else if (ent_ok_q && rec_cur.present) begin
			case (req_q.req_type)
				REQ_HEARTBEAT: begin
					su_rec.last_hb = req_q.now_time;
					su_rec.status  = ST_OK;
				end
				REQ_DL_START: begin
					su_rec.dl_begin = req_q.now_time;
					su_rec.running  = 1'b1;
				end
				REQ_DL_END: begin
					if (rec_cur.running) begin
						su_rec.running = 1'b0;
						if (dl_over) begin
							do_fail = 1'b1;
						end else begin
							su_rec.status = ST_OK;
							su_pass       = 1'b1;
						end
					end
				end
				REQ_CHECKPOINT: begin
					if (rec_cur.seen_cnt <= MAX_CNT) begin
						su_rec.seen_cnt = rec_cur.seen_cnt + 1'b1;
					end
					if (cp_mism) begin
						do_fail  = 1'b1;
						fail_why = ST_WRONG;
					end
				end
				REQ_VERIFY: begin
					if (verify_ok) begin
						su_rec.status = ST_OK;
						su_pass       = 1'b1;
					end else begin
						do_fail  = 1'b1;
						fail_why = ST_WRONG;
					end
					su_rec.seen_cnt = '0;
				end
				default: begin
				end
			endcase
		end
		su_fault = do_fail;
		if (do_fail) begin
			su_rec.status = fail_why;
			su_rec.fails  = fails_inc;
		end
	end

	assign known_s = ent_ok_q && su_rec.present;

	always_comb begin
		res_s.entity_out = req_q.entity;
		res_s.known      = known_s;
		res_s.status     = known_s ? su_rec.status : ST_DEACT;
		res_s.failures   = known_s ? su_rec.fails : 16'd0;
		res_s.fault      = known_s && su_fault;
		res_s.action     = (known_s && su_fault) ? fail_act : ACT_NONE;
		res_s.pass       = known_s && su_pass;
		res_s.last       = 1'b1;
	end

	// Alive check of one table slot during a check-all walk.
	assign ca_fail = rec_cur.present && rec_cur.alive_on && alive_over;

	always_comb begin
		ca_rec = rec_cur;
		if (ca_fail) begin
			ca_rec.status = ST_EXPIRED;
			ca_rec.fails  = fails_inc;
		end
		res_ca.entity_out = 4'(ca_idx_q);
		res_ca.known      = rec_cur.present;
		res_ca.status     = rec_cur.present ? ca_rec.status : ST_DEACT;
		res_ca.failures   = rec_cur.present ? ca_rec.fails : 16'd0;
		res_ca.fault      = ca_fail;
		res_ca.action     = ca_fail ? fail_act : ACT_NONE;
		res_ca.pass       = 1'b0;
		res_ca.last       = ca_last;
	end

	always_comb begin
		nxt      = state_q;
		emit     = 1'b0;
		res      = res_s;
		rec_re   = 1'b0;
		rec_ra   = EAW'(in_req.entity);
		rec_we   = 1'b0;
		rec_wa   = ent_addr;
		rec_wd   = su_rec;
		seq_re   = 1'b0;
		seq_ra   = {ent_addr, seq_idx_sel};
		seq_we   = 1'b0;
		seq_wd   = seq_rd;
		ca_inc   = 1'b0;
		vidx_inc = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					rec_re = 1'b1;
					if (in_req.req_type == REQ_CHECK_ALL) begin
						rec_ra = '0;
						nxt    = S_CA;
					end else begin
						nxt = S_REC;
					end
				end
			end
			S_REC: begin
				if (need_seq) begin
					seq_re = 1'b1;
					nxt    = S_SEQ;
				end else if (need_ver) begin
					seq_re = 1'b1;
					seq_ra = {ent_addr, SAW'(0)};
					nxt    = S_VER;
				end else if (can_emit) begin
					emit   = 1'b1;
					rec_we = rec_write_ok;
					nxt    = S_IDLE;
				end
			end
			S_SEQ: begin
				if (req_q.req_type == REQ_SEQ_ELEM) begin
					seq_wd.exp_val = req_q.checkpoint_value;
				end else begin
					seq_wd.seen_val = req_q.checkpoint_value;
				end
				if (can_emit) begin
					emit   = 1'b1;
					rec_we = rec_write_ok;
					seq_we = 1'b1;
					nxt    = S_IDLE;
				end
			end
			S_VER: begin
				if (ver_bad || (CNT_W'(vidx_q) == rec_cur.seen_cnt - 1'b1)) begin
					if (can_emit) begin
						emit   = 1'b1;
						rec_we = rec_write_ok;
						nxt    = S_IDLE;
					end
				end else begin
					seq_re   = 1'b1;
					seq_ra   = {ent_addr, vidx_q + 1'b1};
					vidx_inc = 1'b1;
				end
			end
			S_CA: begin
				res    = res_ca;
				rec_wd = ca_rec;
				rec_wa = ca_idx_q;
				if (can_emit) begin
					emit   = 1'b1;
					rec_we = ca_fail;
					if (ca_last) begin
						nxt = S_IDLE;
					end else begin
						rec_re = 1'b1;
						rec_ra = ca_idx_q + 1'b1;
						ca_inc = 1'b1;
					end
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			ent_ok_q  <= 1'b0;
			ca_idx_q  <= '0;
			vidx_q    <= '0;
		end else begin
			state_q   <= nxt;
			out_vld_q <= emit || (out_vld_q && !out_ready);
			if (rec_we) begin
				valid_q[rec_wa] <= 1'b1;
			end
			if (rec_re) begin
				vld_s1 <= valid_q[rec_ra];
			end
			if (state_q == S_IDLE && in_valid) begin
				ent_ok_q <= (32'(in_req.entity) < 32'(NUM_ENTITIES));
				ca_idx_q <= '0;
			end else if (ca_inc) begin
				ca_idx_q <= ca_idx_q + 1'b1;
			end
			if (state_q == S_REC) begin
				vidx_q <= '0;
			end else if (vidx_inc) begin
				vidx_q <= vidx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_req;
		end
		if (seq_re) begin
			seq_ra_q <= seq_ra;
		end
		if (emit) begin
			out_q <= res;
		end
	end

	`WSM_ASSERT(a_accept_leaves_idle, clk, arst_n,
		(in_valid && in_ready) |=> (state_q != S_IDLE), "accepted request did not start")
	`WSM_ASSERT(a_fault_is_known, clk, arst_n,
		(emit && res.fault) |-> res.known, "fault reported for unknown entity")
	`WSM_ASSERT(a_fails_monotonic, clk, arst_n,
		rec_we |-> (rec_wd.fails >= rec_cur.fails), "failure count decreased")
	`WSM_ASSERT(a_verify_in_range, clk, arst_n,
		(state_q == S_VER) |-> (CNT_W'(vidx_q) < MAX_CNT), "verify index out of range")

endmodule

[hdl/watchdog_supervision_manager.sv]
// ----------------------------------------------------------------------------
// Watchdog supervision manager
// Alive, deadline and logical supervision of a table of entities.
// ----------------------------------------------------------------------------
// One request is handled at a time. A single-entity request reads the entity
// table, then updates the record and writes it back; one that touches the
// checkpoint table (sequence element write, checkpoint) also reads and writes
// back one slot there. A verify over n recorded checkpoints compares one
// checkpoint slot per cycle through the single read port of the checkpoint
// table and stops at the first mismatch. A check-all request walks the entity
// table one slot per cycle unless stalled and returns NUM_ENTITIES results.
// The entity table needs no clearing pass after reset. Result beats wait in
// an output register and back pressure stalls the sequencer.
`timescale 1ns / 1ps

module watchdog_supervision_manager import wsm_pkg::*; #(
	parameter int NUM_ENTITIES = NUM_ENTITIES_DEF,
	parameter int MAX_SEQ      = MAX_SEQ_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// entity, now_time, checkpoint_value, seq_index, seq_length, period,
	// tolerance, budget, zero fill
	input  logic [103:0] s_axis_tdata,
	// req_type
	input  logic [3:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// entity_out, known, status, failures, fault, action, pass, zero fill
	output logic [31:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	thr_t thr_q;
	req_t in_req;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.restart   <= RESTART_RST;
			thr_q.partition <= PARTITION_RST;
			thr_q.safe      <= SAFE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESTART:   thr_q.restart   <= cfg_data;
				CFG_PARTITION: thr_q.partition <= cfg_data;
				CFG_SAFE:      thr_q.safe      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		in_req.req_type         = s_axis_tuser;
		in_req.entity           = s_axis_tdata[3:0];
		in_req.now_time         = s_axis_tdata[35:4];
		in_req.checkpoint_value = s_axis_tdata[43:36];
		in_req.seq_index        = s_axis_tdata[46:44];
		in_req.seq_length       = s_axis_tdata[50:47];
		in_req.period           = s_axis_tdata[66:51];
		in_req.tolerance        = s_axis_tdata[82:67];
		in_req.budget           = s_axis_tdata[98:83];
	end

	wsm_core #(.NUM_ENTITIES(NUM_ENTITIES), .MAX_SEQ(MAX_SEQ)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (in_req),
		.thr       (thr_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {5'd0, res.pass, res.action, res.fault, res.failures,
		res.status, res.known, res.entity_out};
	assign m_axis_tlast = res.last;

endmodule
